@@ rtl/tvm_pkg.sv @@
// ----------------------------------------------------------------------------
// tvm_pkg
// Shared types, widths and constants of the tracker voice mixer.
// ----------------------------------------------------------------------------
package tvm_pkg;

  localparam int SAMPLE_MEM_DEPTH_DEF = 65536;
  localparam int VOICES_DEF           = 4;

  localparam int ADDR_W = 16;
  localparam int LEN_W  = 17;
  localparam int VOL_W  = 8;
  localparam int POS_W  = 33;
  localparam int STEP_W = 32;
  localparam int PER_W  = 12;
  localparam int RATE_W = 17;
  localparam int SMP_W  = 16;
  localparam int ACC_W  = 18;

  localparam int DIV_NUM_W = 38;
  localparam int DIV_DEN_W = 29;
  localparam int DIV_CNT_W = 6;

  localparam logic [DIV_NUM_W-1:0] PITCH_NUM    = {22'd3546895, 16'd0};
  localparam logic [RATE_W-1:0]    RATE_RESET   = 17'd44100;
  localparam logic [PER_W-1:0]     PERIOD_LIMIT = 12'd2000;
  localparam logic [VOL_W-1:0]     VOL_MAX      = 8'd64;
  localparam logic [LEN_W-1:0]     LEN_MAX      = 17'd65536;
  localparam logic signed [ACC_W-1:0] MIX_MAX   = 18'sd28000;
  localparam logic signed [ACC_W-1:0] MIX_MIN   = -18'sd28000;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_NOTE  = 2'd1,
    KIND_MIX   = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic {
    CFG_PLAYING = 1'b0,
    CFG_RATE    = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE, S_WADDR, S_NRD, S_NUPD, S_NMUL, S_NDIV,
    S_MRD, S_MCHK, S_MLOOP, S_MADR, S_MSMP, S_EMIT
  } state_t;

  typedef struct packed {
    logic              active;
    logic              has_sample;
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  length;
    logic [ADDR_W-1:0] loop_start;
    logic [LEN_W-1:0]  loop_length;
    logic              looping;
    logic [VOL_W-1:0]  volume;
    logic [POS_W-1:0]  position;
    logic [STEP_W-1:0] step;
  } voice_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_CNT_W-1:0] nbits;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
    logic [DIV_DEN_W-1:0] rem;
  } div_rsp_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] x);
    return (x > LEN_MAX) ? LEN_MAX : x;
  endfunction

  function automatic logic [SMP_W-1:0] clamp_mix(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] y;
    y = x;
    if (x > MIX_MAX) y = MIX_MAX;
    if (x < MIX_MIN) y = MIX_MIN;
    return y[SMP_W-1:0];
  endfunction

endpackage

@@ rtl/tvm_div.sv @@
// ----------------------------------------------------------------------------
// tvm_div
// Radix-2 restoring divider, one quotient bit per cycle, variable length.
// ----------------------------------------------------------------------------
module tvm_div import tvm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_NUM_W-1:0] num_r;
  logic [DIV_NUM_W-1:0] quo_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W:0]   trial;
  logic                 ge;
  logic [DIV_DEN_W-1:0] rem_nxt;
  logic [DIV_CNT_W-1:0] shamt;

  assign trial   = {rem_r, num_r[DIV_NUM_W-1]};
  assign ge      = trial >= {1'b0, den_r};
  assign rem_nxt = ge ? DIV_DEN_W'(trial - {1'b0, den_r}) : DIV_DEN_W'(trial);
  assign shamt   = DIV_CNT_W'(DIV_NUM_W) - req.nbits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.num << shamt;
      den_r <= req.den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[DIV_NUM_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIV_NUM_W-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

@@ rtl/tvm_sample_mem.sv @@
// ----------------------------------------------------------------------------
// tvm_sample_mem
// Sample byte store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tvm_sample_mem import tvm_pkg::*; #(
  parameter int DEPTH = SAMPLE_MEM_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/tracker_voice_mixer_top.sv @@
// ----------------------------------------------------------------------------
// tracker_voice_mixer_top
// Four-voice tracker sample mixer: sample store, voice state memory and
// a sequencer that updates one voice entry at a time.
// ----------------------------------------------------------------------------
// One item at a time; the input stalls until the current item is done. A note
// event that carries a valid period runs the 38-step pitch division in the
// shared divider, which is skipped at zero output rate. A mix request reads
// the sample of each sounding voice, skips silent ones and uses the divider
// for each loop wrap; the voice state memory serves one entry per cycle and
// the divider yields one bit per cycle. A finished frame waits in the output
// register while the next item is taken.
module tracker_voice_mixer_top import tvm_pkg::*; #(
  parameter int SAMPLE_MEM_DEPTH = SAMPLE_MEM_DEPTH_DEF,
  parameter int VOICES           = VOICES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_kind,
  input  logic [ADDR_W-1:0]        in_mem_addr,
  input  logic [7:0]               in_mem_byte,
  input  logic [1:0]               in_channel,
  input  logic                     in_instr_valid,
  input  logic [LEN_W-1:0]         in_instr_length,
  input  logic [ADDR_W-1:0]        in_instr_repeat_start,
  input  logic [LEN_W-1:0]         in_instr_repeat_length,
  input  logic [VOL_W-1:0]         in_instr_volume,
  input  logic [PER_W-1:0]         in_period,
  input  logic                     in_volume_valid,
  input  logic [VOL_W-1:0]         in_volume_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [SMP_W-1:0]  out_left_sample,
  output logic signed [SMP_W-1:0]  out_right_sample,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [RATE_W-1:0]        cfg_data
);

  localparam int AW  = $clog2(SAMPLE_MEM_DEPTH);
  localparam int VW  = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int VCW = $clog2(VOICES + 1);
  localparam int PROD_W = PER_W + RATE_W;

  function automatic logic [AW-1:0] wrap_addr(input logic [ADDR_W+1:0] a);
    logic [31:0] x;
    x = 32'(a);
    for (int k = 7; k >= 0; k--) begin
      if (x >= (32'(SAMPLE_MEM_DEPTH) << k)) x = x - (32'(SAMPLE_MEM_DEPTH) << k);
    end
    return AW'(x);
  endfunction

  state_t state_r, state_nxt;

  logic              playing_r;
  logic [RATE_W-1:0] rate_r;

  logic [ADDR_W-1:0] it_addr_r;
  logic [7:0]        it_byte_r;
  logic [1:0]        it_chan_r;
  logic              it_ivalid_r;
  logic [LEN_W-1:0]  it_len_r;
  logic [ADDR_W-1:0] it_rs_r;
  logic [LEN_W-1:0]  it_rl_r;
  logic [VOL_W-1:0]  it_ivol_r;
  logic [PER_W-1:0]  it_per_r;
  logic              it_vvalid_r;
  logic [VOL_W-1:0]  it_vval_r;

  voice_t                  row_r, row_nxt;
  logic [VCW-1:0]          v_r, v_nxt;
  logic signed [ACC_W-1:0] ml_r, ml_nxt, mr_r, mr_nxt;
  logic [PROD_W-1:0]       prod_r, prod_nxt;
  logic [15:0]             lp_lo_r, lp_lo_nxt;
  logic [ADDR_W+1:0]       saddr_r, saddr_nxt;

  logic                    out_valid_r;
  logic signed [SMP_W-1:0] out_left_r, out_right_r;

  voice_t         vmem [VOICES];
  logic [VOICES-1:0] vld_r;
  voice_t         vrd_row_r;
  logic           vrd_vld_r;
  logic           vrd_en, vwr_en;
  logic [VW-1:0]  vrd_idx, vwr_idx;
  voice_t         vwr_row;
  voice_t         cur_row;

  logic          s_wr_en, s_rd_en;
  logic [AW-1:0] s_wr_addr, s_rd_addr;
  logic [7:0]    s_wr_data, smp_rd;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                    accept;
  logic                    chan_ok;
  logic                    last_v;
  logic [LEN_W-1:0]        chk_ip;
  logic [POS_W-1:0]        chk_lp;
  logic                    chk_skip, chk_past, chk_wrap;
  logic [POS_W-1:0]        wrap_pos;
  logic                    wrap_stop;
  logic [LEN_W-1:0]        inst_len;
  logic                    inst_stop, per_ok;
  logic [VOL_W-1:0]        vol_new;
  logic [STEP_W-1:0]       step_sat;
  logic signed [7:0]       raw_s;
  logic signed [16:0]      mul_s;
  logic signed [13:0]      smp_s, smp_half;
  logic [3:0]              v4;
  logic                    pan_left;
  logic                    emit_go;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign chan_ok  = int'(in_channel) < VOICES;
  assign last_v   = (v_r == VCW'(VOICES - 1));
  assign cur_row  = vrd_vld_r ? vrd_row_r : '0;

  assign chk_ip    = cur_row.position[POS_W-1:16];
  assign chk_lp    = cur_row.position - {cur_row.length, 16'd0};
  assign chk_skip  = !cur_row.active || !cur_row.has_sample || (cur_row.length == '0);
  assign chk_past  = chk_ip >= cur_row.length;
  assign chk_wrap  = cur_row.looping && (cur_row.loop_length != '0);
  assign wrap_pos  = POS_W'({row_r.loop_start, 16'd0}) + {div_rsp.rem[LEN_W-1:0], lp_lo_r};
  assign wrap_stop = wrap_pos[POS_W-1:16] >= row_r.length;

  assign inst_len  = clamp_len(it_len_r);
  assign inst_stop = it_ivalid_r && (inst_len == '0);
  assign per_ok    = (it_per_r != '0) && (it_per_r < PERIOD_LIMIT);
  assign vol_new   = (it_vval_r > VOL_MAX) ? VOL_MAX : it_vval_r;
  assign step_sat  = (|div_rsp.quo[DIV_NUM_W-1:STEP_W]) ? '1 : div_rsp.quo[STEP_W-1:0];

  assign raw_s    = signed'(smp_rd);
  assign mul_s    = raw_s * signed'({1'b0, row_r.volume});
  assign smp_s    = 14'(mul_s >>> 3);
  assign smp_half = smp_s >>> 1;
  assign v4       = 4'(v_r);
  assign pan_left = (v4[1:0] == 2'd0) || (v4[1:0] == 2'd3);

  assign emit_go = (state_r == S_EMIT) && (!out_valid_r || !out_stall);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (kind_t'(in_kind))
            KIND_WRITE: state_nxt = S_WADDR;
            KIND_NOTE:  state_nxt = chan_ok ? S_NRD : S_IDLE;
            KIND_MIX:   state_nxt = playing_r ? S_MRD : S_EMIT;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_WADDR: state_nxt = S_IDLE;
      S_NRD:   state_nxt = S_NUPD;
      S_NUPD:  state_nxt = (!inst_stop && per_ok) ? S_NMUL : S_IDLE;
      S_NMUL:  state_nxt = (prod_r == '0) ? S_IDLE : S_NDIV;
      S_NDIV:  if (div_rsp.done) state_nxt = S_IDLE;
      S_MRD:   state_nxt = S_MCHK;
      S_MCHK: begin
        if (chk_skip || (chk_past && !chk_wrap)) state_nxt = last_v ? S_EMIT : S_MRD;
        else if (chk_past) state_nxt = S_MLOOP;
        else state_nxt = S_MADR;
      end
      S_MLOOP: begin
        if (div_rsp.done) begin
          if (wrap_stop) state_nxt = last_v ? S_EMIT : S_MRD;
          else state_nxt = S_MADR;
        end
      end
      S_MADR:  state_nxt = S_MSMP;
      S_MSMP:  state_nxt = last_v ? S_EMIT : S_MRD;
      S_EMIT:  if (emit_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    voice_t r;
    r         = row_r;
    row_nxt   = row_r;
    v_nxt     = v_r;
    ml_nxt    = ml_r;
    mr_nxt    = mr_r;
    prod_nxt  = prod_r;
    lp_lo_nxt = lp_lo_r;
    saddr_nxt = saddr_r;
    vrd_en    = 1'b0;
    vrd_idx   = v_r[VW-1:0];
    vwr_en    = 1'b0;
    vwr_idx   = v_r[VW-1:0];
    vwr_row   = row_r;
    s_wr_en   = 1'b0;
    s_wr_addr = AW'(it_addr_r);
    s_wr_data = it_byte_r;
    s_rd_en   = 1'b0;
    s_rd_addr = AW'(saddr_r);
    div_req   = '0;
    case (state_r)
      S_IDLE: begin
        v_nxt  = '0;
        ml_nxt = '0;
        mr_nxt = '0;
      end
      S_WADDR: begin
        s_wr_en   = 1'b1;
        s_wr_addr = wrap_addr((ADDR_W+2)'(it_addr_r));
      end
      S_NRD: begin
        vrd_en  = 1'b1;
        vrd_idx = VW'(it_chan_r);
      end
      S_NUPD: begin
        r = cur_row;
        if (inst_stop) r.active = 1'b0;
        else if (it_ivalid_r) begin
          r.has_sample  = 1'b1;
          r.start       = it_addr_r;
          r.length      = inst_len;
          r.loop_start  = it_rs_r;
          r.loop_length = clamp_len(it_rl_r);
          r.looping     = (clamp_len(it_rl_r) != '0);
          r.volume      = it_ivol_r;
          r.active      = 1'b1;
        end
        row_nxt  = r;
        prod_nxt = PROD_W'(it_per_r) * PROD_W'(rate_r);
        if (inst_stop || !per_ok) begin
          if (it_vvalid_r) r.volume = vol_new;
          vwr_en  = 1'b1;
          vwr_idx = VW'(it_chan_r);
          vwr_row = r;
        end
      end
      S_NMUL, S_NDIV: begin
        r.step     = (state_r == S_NMUL) ? '1 : step_sat;
        r.position = '0;
        if (r.has_sample && (r.length != '0)) r.active = 1'b1;
        if (it_vvalid_r) r.volume = vol_new;
        vwr_idx = VW'(it_chan_r);
        vwr_row = r;
        if (state_r == S_NMUL && prod_r != '0) begin
          div_req.start = 1'b1;
          div_req.num   = PITCH_NUM;
          div_req.nbits = DIV_CNT_W'(DIV_NUM_W);
          div_req.den   = DIV_DEN_W'(prod_r);
        end else begin
          vwr_en = (state_r == S_NMUL) || div_rsp.done;
        end
      end
      S_MRD: vrd_en = 1'b1;
      S_MCHK: begin
        row_nxt   = cur_row;
        lp_lo_nxt = chk_lp[15:0];
        saddr_nxt = (ADDR_W+2)'(cur_row.start) + (ADDR_W+2)'(chk_ip);
        if (!chk_skip && chk_past) begin
          if (chk_wrap) begin
            div_req.start = 1'b1;
            div_req.num   = DIV_NUM_W'(chk_lp[POS_W-1:16]);
            div_req.nbits = DIV_CNT_W'(LEN_W);
            div_req.den   = DIV_DEN_W'(cur_row.loop_length);
          end else begin
            r        = cur_row;
            r.active = 1'b0;
            vwr_en   = 1'b1;
            vwr_row  = r;
          end
        end
        if (chk_skip || (chk_past && !chk_wrap)) v_nxt = v_r + 1'b1;
      end
      S_MLOOP: begin
        if (div_rsp.done) begin
          r.position = wrap_pos;
          row_nxt    = r;
          saddr_nxt  = (ADDR_W+2)'(row_r.start) + (ADDR_W+2)'(wrap_pos[POS_W-1:16]);
          if (wrap_stop) begin
            r.active = 1'b0;
            vwr_en   = 1'b1;
            vwr_row  = r;
            v_nxt    = v_r + 1'b1;
          end
        end
      end
      S_MADR: begin
        s_rd_en   = 1'b1;
        s_rd_addr = wrap_addr(saddr_r);
      end
      S_MSMP: begin
        ml_nxt = ml_r + (pan_left ? ACC_W'(smp_s) : ACC_W'(smp_half));
        mr_nxt = mr_r + (pan_left ? ACC_W'(smp_half) : ACC_W'(smp_s));
        r.position = row_r.position + POS_W'(row_r.step);
        vwr_en  = 1'b1;
        vwr_row = r;
        v_nxt   = v_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit_go) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      playing_r <= 1'b0;
      rate_r    <= RATE_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PLAYING: playing_r <= cfg_data[0];
        CFG_RATE:    rate_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      it_addr_r   <= in_mem_addr;
      it_byte_r   <= in_mem_byte;
      it_chan_r   <= in_channel;
      it_ivalid_r <= in_instr_valid;
      it_len_r    <= in_instr_length;
      it_rs_r     <= in_instr_repeat_start;
      it_rl_r     <= in_instr_repeat_length;
      it_ivol_r   <= in_instr_volume;
      it_per_r    <= in_period;
      it_vvalid_r <= in_volume_valid;
      it_vval_r   <= in_volume_value;
    end
    row_r   <= row_nxt;
    v_r     <= v_nxt;
    ml_r    <= ml_nxt;
    mr_r    <= mr_nxt;
    prod_r  <= prod_nxt;
    lp_lo_r <= lp_lo_nxt;
    saddr_r <= saddr_nxt;
    if (emit_go) begin
      out_left_r  <= clamp_mix(ml_r);
      out_right_r <= clamp_mix(mr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (vwr_en) vmem[vwr_idx] <= vwr_row;
    if (vrd_en) vrd_row_r <= vmem[vrd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      vrd_vld_r <= 1'b0;
    end else begin
      if (vwr_en) vld_r[vwr_idx] <= 1'b1;
      if (vrd_en) vrd_vld_r <= vld_r[vrd_idx];
    end
  end

  tvm_sample_mem #(
    .DEPTH (SAMPLE_MEM_DEPTH),
    .AW    (AW)
  ) u_smem (
    .clk     (clk),
    .wr_en   (s_wr_en),
    .wr_addr (s_wr_addr),
    .wr_data (s_wr_data),
    .rd_en   (s_rd_en),
    .rd_addr (s_rd_addr),
    .rd_data (smp_rd)
  );

  tvm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_valid        = out_valid_r;
  assign out_left_sample  = out_left_r;
  assign out_right_sample = out_right_r;

`ifndef SYNTHESIS
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (ACC_W'(out_left_sample) <= MIX_MAX) && (ACC_W'(out_left_sample) >= MIX_MIN)
      && (ACC_W'(out_right_sample) <= MIX_MAX) && (ACC_W'(out_right_sample) >= MIX_MIN))
    else $error("mix result out of range");

  a_silent_mix: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_kind == KIND_MIX) && !playing_r |=> (state_r == S_EMIT) && (ml_r == '0))
    else $error("silent mix did not go straight to output");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_NDIV) || (state_r == S_MLOOP))
    else $error("divider finished outside a wait state");

  a_smp_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MSMP) |-> $past(s_rd_en))
    else $error("sample used without a read");
`endif

endmodule

@@ tb/tb_tracker_voice_mixer_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tracker_voice_mixer_top
// Drives sample writes, note events and mix requests into the four-voice
// mixer with random gaps and output stalls, predicts every stereo frame
// from an internal voice model and compares each frame field by field.
// ----------------------------------------------------------------------------
module tb_tracker_voice_mixer_top import tvm_pkg::*; ();

  localparam int REGION_BASE = 'hFF00;
  localparam int REGION_SIZE = 512;

  typedef struct {
    kind_t       kind;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [1:0]  chan;
    logic        ins_ok;
    logic [16:0] ins_len;
    logic [15:0] rep_start;
    logic [16:0] rep_len;
    logic [7:0]  ins_vol;
    logic [11:0] per;
    logic        vol_ok;
    logic [7:0]  vol_val;
  } mixer_item_t;

  typedef struct {
    logic [15:0] left;
    logic [15:0] right;
  } frame_t;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [1:0] in_kind;
  logic [15:0] in_mem_addr;
  logic [7:0] in_mem_byte;
  logic [1:0] in_channel;
  logic in_instr_valid;
  logic [16:0] in_instr_length;
  logic [15:0] in_instr_repeat_start;
  logic [16:0] in_instr_repeat_length;
  logic [7:0] in_instr_volume;
  logic [11:0] in_period;
  logic in_volume_valid;
  logic [7:0] in_volume_value;
  logic out_valid, out_stall;
  logic signed [15:0] out_left_sample, out_right_sample;
  logic cfg_we;
  logic cfg_index;
  logic [16:0] cfg_data;

  tracker_voice_mixer_top uut (.*);

  // voice model
  logic [7:0]  sample_mem [65536];
  bit          vc_active [4];
  bit          vc_loaded [4];
  logic [15:0] vc_start [4];
  logic [16:0] vc_len [4];
  logic [15:0] vc_loop_start [4];
  logic [16:0] vc_loop_len [4];
  bit          vc_looping [4];
  logic [7:0]  vc_vol [4];
  logic [32:0] vc_pos [4];
  logic [31:0] vc_step [4];
  bit          md_playing;
  logic [16:0] md_rate;

  frame_t frames_due [$];
  int errors = 0;
  int idle_cycles = 0;
  int rx_hold = 0;
  int rx_run = 0;
  bit rx_level = 0;
  bit tx_eager = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [16:0] len_clip(logic [16:0] x);
    return (x > 17'd65536) ? 17'd65536 : x;
  endfunction

  function automatic logic [15:0] mix_clip(int x);
    if (x > 28000) x = 28000;
    if (x < -28000) x = -28000;
    return x[15:0];
  endfunction

  function automatic void apply_note(mixer_item_t it);
    int c;
    longint unsigned den, q;
    c = int'(it.chan);
    if (it.ins_ok) begin
      if (len_clip(it.ins_len) == 0) begin
        vc_active[c] = 0;
        if (it.vol_ok) vc_vol[c] = (it.vol_val > 64) ? 8'd64 : it.vol_val;
        return;
      end
      vc_loaded[c] = 1;
      vc_start[c] = it.addr;
      vc_len[c] = len_clip(it.ins_len);
      vc_loop_start[c] = it.rep_start;
      vc_loop_len[c] = len_clip(it.rep_len);
      vc_looping[c] = vc_loop_len[c] != 0;
      vc_vol[c] = it.ins_vol;
      vc_active[c] = 1;
    end
    if (it.per > 0 && it.per < 2000) begin
      den = longint'(it.per) * longint'(md_rate);
      q = (den == 0) ? 64'hFFFF_FFFF : ((64'd3546895 << 16) / den);
      vc_step[c] = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
      vc_pos[c] = '0;
      if (vc_loaded[c] && vc_len[c] > 0) vc_active[c] = 1;
    end
    if (it.vol_ok) vc_vol[c] = (it.vol_val > 64) ? 8'd64 : it.vol_val;
  endfunction

  function automatic frame_t mix_frame();
    frame_t f;
    int acc_l, acc_r, raw, smp;
    longint unsigned p, ip, lp;
    acc_l = 0;
    acc_r = 0;
    for (int v = 0; v < 4; v++) begin
      if (!vc_active[v] || !vc_loaded[v] || vc_len[v] == 0) continue;
      p = vc_pos[v];
      ip = p >> 16;
      if (ip >= vc_len[v]) begin
        if (vc_looping[v] && vc_loop_len[v] > 0) begin
          lp = (p - (longint'(vc_len[v]) << 16)) % (longint'(vc_loop_len[v]) << 16);
          p = (longint'(vc_loop_start[v]) << 16) + lp;
          vc_pos[v] = p[32:0];
          ip = p >> 16;
        end else begin
          vc_active[v] = 0;
          continue;
        end
      end
      if (ip >= vc_len[v]) begin
        vc_active[v] = 0;
        continue;
      end
      raw = int'($signed(sample_mem[16'(vc_start[v] + ip)]));
      smp = (raw * int'(vc_vol[v])) >>> 3;
      if (v == 0 || v == 3) begin
        acc_l += smp;
        acc_r += smp >>> 1;
      end else begin
        acc_l += smp >>> 1;
        acc_r += smp;
      end
      p = p + vc_step[v];
      vc_pos[v] = p[32:0];
    end
    f.left = mix_clip(acc_l);
    f.right = mix_clip(acc_r);
    return f;
  endfunction

  function automatic void predict(mixer_item_t it);
    frame_t f;
    case (it.kind)
      KIND_WRITE: sample_mem[it.addr] = it.data;
      KIND_NOTE: apply_note(it);
      KIND_MIX: begin
        f.left = 0;
        f.right = 0;
        if (md_playing) f = mix_frame();
        frames_due.push_back(f);
      end
      default: ;
    endcase
  endfunction

  function automatic mixer_item_t junk_item(kind_t k);
    mixer_item_t it;
    it.kind = k;
    it.addr = 16'($urandom);
    it.data = 8'($urandom);
    it.chan = 2'($urandom);
    it.ins_ok = 1'($urandom);
    it.ins_len = 17'($urandom);
    it.rep_start = 16'($urandom);
    it.rep_len = 17'($urandom);
    it.ins_vol = 8'($urandom);
    it.per = 12'($urandom);
    it.vol_ok = 1'($urandom);
    it.vol_val = 8'($urandom);
    return it;
  endfunction

  function automatic mixer_item_t note_item(int ch, bit iv, int start, int len, int rs,
                                            int rl, int ivol, int per, bit vv, int vval);
    mixer_item_t it;
    it = junk_item(KIND_NOTE);
    it.chan = 2'(ch);
    it.ins_ok = iv;
    it.addr = 16'(start);
    it.ins_len = 17'(len);
    it.rep_start = 16'(rs);
    it.rep_len = 17'(rl);
    it.ins_vol = 8'(ivol);
    it.per = 12'(per);
    it.vol_ok = vv;
    it.vol_val = 8'(vval);
    return it;
  endfunction

  function automatic mixer_item_t write_item(int a, int d);
    mixer_item_t it;
    it = junk_item(KIND_WRITE);
    it.addr = 16'(a);
    it.data = 8'(d);
    return it;
  endfunction

  function automatic int pick_gap();
    int r;
    if (tx_eager) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(mixer_item_t it, int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1;
    in_kind <= it.kind;
    in_mem_addr <= it.addr;
    in_mem_byte <= it.data;
    in_channel <= it.chan;
    in_instr_valid <= it.ins_ok;
    in_instr_length <= it.ins_len;
    in_instr_repeat_start <= it.rep_start;
    in_instr_repeat_length <= it.rep_len;
    in_instr_volume <= it.ins_vol;
    in_period <= it.per;
    in_volume_valid <= it.vol_ok;
    in_volume_value <= it.vol_val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict(it);
  endtask

  task automatic send(mixer_item_t it);
    send_item(it, pick_gap());
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_config(bit play, int rate);
    drain();
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= CFG_PLAYING;
    cfg_data <= 17'(play);
    md_playing = play;
    @(negedge clk);
    cfg_index <= CFG_RATE;
    cfg_data <= 17'(rate);
    md_rate = 17'(rate);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic test_fill_store();
    tx_eager = 1;
    for (int a = 0; a < REGION_SIZE; a++)
      send_item(write_item(REGION_BASE + a, int'($urandom)), 0);
    send_item(write_item(16'h0000, 8'h80), 0);
    send_item(write_item(16'h0001, 8'h7F), 0);
    send_item(write_item(16'hFFFF, 8'hFF), 0);
    send_item(write_item(16'h0002, 8'h00), 0);
    tx_eager = 0;
  endtask

  task automatic test_directed();
    set_config(1, 44100);
    send(junk_item(KIND_MIX));
    send(junk_item(KIND_NONE));
    send(note_item(0, 1, 0, 8, 0, 0, 255, 1, 0, 0));
    send(note_item(1, 1, 16'hFFFC, 17'h1FFFF, 0, 17'h1FFFF, 64, 1999, 1, 255));
    send(note_item(2, 1, 100, 4, 1, 2, 200, 1, 0, 0));
    send(note_item(3, 1, 200, 4, 10, 3, 100, 1, 0, 0));
    repeat (3) send(junk_item(KIND_MIX));
    send(note_item(0, 0, 0, 0, 0, 0, 0, 0, 1, 0));
    send(note_item(0, 0, 0, 0, 0, 0, 0, 2000, 1, 40));
    send(note_item(0, 0, 0, 0, 0, 0, 0, 4095, 0, 0));
    send(note_item(1, 1, 0, 0, 0, 0, 0, 100, 0, 0));
    send(note_item(2, 0, 0, 0, 0, 0, 0, 300, 0, 0));
    repeat (3) send(junk_item(KIND_MIX));
    set_config(1, 0);
    send(note_item(0, 1, 16'hFF00, 300, 20, 50, 30, 500, 0, 0));
    repeat (3) send(junk_item(KIND_MIX));
    send(note_item(3, 0, 0, 0, 0, 0, 0, 1, 1, 64));
    send(junk_item(KIND_MIX));
  endtask

  function automatic mixer_item_t random_item();
    mixer_item_t it;
    int r, s;
    r = $urandom_range(0, 99);
    if (r < 45) return junk_item(KIND_MIX);
    if (r < 88) begin
      it = junk_item(KIND_NOTE);
      it.ins_ok = ($urandom_range(0, 9) < 7);
      s = $urandom_range(0, REGION_SIZE - 1);
      it.addr = 16'(REGION_BASE + s);
      r = $urandom_range(0, 9);
      if (r == 0) it.ins_len = '0;
      else it.ins_len = 17'($urandom_range(1, REGION_SIZE - s));
      if ($urandom_range(0, 9) < 8) it.rep_start = 16'($urandom_range(0, 600));
      r = $urandom_range(0, 9);
      if (r < 3) it.rep_len = '0;
      else if (r < 9) it.rep_len = 17'($urandom_range(1, 300));
      if ($urandom_range(0, 9) < 7) it.per = 12'($urandom_range(1, 1999));
      return it;
    end
    if (r < 96) return junk_item(KIND_WRITE);
    return junk_item(KIND_NONE);
  endfunction

  task automatic test_random();
    bit plays [6] = '{1, 1, 0, 1, 1, 1};
    int rates [6] = '{8000, 96000, 44100, 131071, 44100, 0};
    for (int ph = 0; ph < 6; ph++) begin
      set_config(plays[ph], rates[ph]);
      for (int n = 0; n < 78; n++) begin
        if (n >= 20 && n < 45) tx_eager = 1;
        else tx_eager = 0;
        send(random_item());
      end
      tx_eager = 0;
    end
  endtask

  task automatic test_backpressure();
    set_config(1, 22050);
    for (int c = 0; c < 4; c++)
      send(note_item(c, 1, REGION_BASE + $urandom_range(0, REGION_SIZE - 400), 400, 50,
                     100, int'($urandom), $urandom_range(100, 900), 0, 0));
    rx_hold = 400;
    for (int n = 0; n < 40; n++) send_item(junk_item(KIND_MIX), 0);
    drain();
  endtask

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_stall <= 1;
      rx_hold <= rx_hold - 1;
    end else begin
      if (rx_run == 0) begin
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
          rx_level = 0;
          rx_run = $urandom_range(1, 20);
        end else if (r < 95) begin
          rx_level = 1;
          rx_run = $urandom_range(1, 3);
        end else begin
          rx_level = 1;
          rx_run = $urandom_range(10, 40);
        end
      end
      out_stall <= rx_level;
      rx_run = rx_run - 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (frames_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected frame L=%0d R=%0d", $time,
                 out_left_sample, out_right_sample);
      end else begin
        frame_t f;
        f = frames_due.pop_front();
        if (out_left_sample !== f.left) begin
          errors++;
          $display("%0t: left expected %0d actual %0d", $time,
                   $signed(f.left), out_left_sample);
        end
        if (out_right_sample !== f.right) begin
          errors++;
          $display("%0t: right expected %0d actual %0d", $time,
                   $signed(f.right), out_right_sample);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 4000) begin
      $display("tb_tracker_voice_mixer_top: FAIL");
      $finish;
    end
  end

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_kind = KIND_WRITE;
    in_mem_addr = 0;
    in_mem_byte = 0;
    in_channel = 0;
    in_instr_valid = 0;
    in_instr_length = 0;
    in_instr_repeat_start = 0;
    in_instr_repeat_length = 0;
    in_instr_volume = 0;
    in_period = 0;
    in_volume_valid = 0;
    in_volume_value = 0;
    out_stall = 0;
    cfg_we = 0;
    cfg_index = CFG_PLAYING;
    cfg_data = 0;
    md_playing = 0;
    md_rate = 44100;
    for (int v = 0; v < 4; v++) begin
      vc_active[v] = 0;
      vc_loaded[v] = 0;
      vc_start[v] = 0;
      vc_len[v] = 0;
      vc_loop_start[v] = 0;
      vc_loop_len[v] = 0;
      vc_looping[v] = 0;
      vc_vol[v] = 0;
      vc_pos[v] = 0;
      vc_step[v] = 0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    test_fill_store();
    test_directed();
    test_random();
    test_backpressure();
    drain();
    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("tb_tracker_voice_mixer_top: PASS");
    else
      $display("tb_tracker_voice_mixer_top: FAIL");
    $finish;
  end

endmodule
